// File: src/hsv_pkg.sv
package hsv_pkg;

  // Field widths of the pixel channels.
  localparam int unsigned HUE_W = 13;
  localparam int unsigned PCT_W = 11;
  localparam int unsigned CH_W  = 8;

  // Default number of fraction bits in the internal fixed-point words.
  localparam int unsigned FRAC_BITS_DEFAULT = 16;

  // Upper ends of the valid input ranges (degrees and percent times 16).
  localparam logic [HUE_W-1:0] HUE_FULL = 13'd5760;
  localparam logic [PCT_W-1:0] PCT_FULL = 11'd1600;

  // Percent to fraction: 1600 = 25 * 64. The quotient by 25 comes from a
  // reciprocal multiply that is exact for every 11-bit input.
  localparam int unsigned PCT_SHIFT       = 6;
  localparam int unsigned PCT_RESID_DIV   = 25;
  localparam int unsigned PCT_RECIP_W     = 12;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 12'd2622;
  localparam int unsigned PCT_RECIP_SHIFT = 16;
  localparam int unsigned PCT_Q_W         = 7;
  localparam int unsigned RES_W           = 5;
  localparam int unsigned PCT_TAB_N       = 32;

  // Hue sectors of 60 degrees: 960 = 15 * 64.
  localparam int unsigned SECTOR_SPAN = 960;
  localparam int unsigned K_W         = 10;
  localparam int unsigned SPAN_SHIFT  = 6;
  localparam int unsigned SPAN_ODD    = 15;
  localparam int unsigned SPAN_RECIP_W = 32;
  localparam logic [SPAN_RECIP_W-1:0] SPAN_RECIP = 32'h1111_1111;

  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW   = 3'd0,
    SECTOR_YELLOW_GREEN = 3'd1,
    SECTOR_GREEN_CYAN   = 3'd2,
    SECTOR_CYAN_BLUE    = 3'd3,
    SECTOR_BLUE_MAGENTA = 3'd4,
    SECTOR_MAGENTA_RED  = 3'd5
  } sector_e;

  // Per-pixel control that travels down the pipeline with the data.
  typedef struct packed {
    logic    err;
    sector_e sector;
  } hsv_ctrl_t;

endpackage

// File: src/hsv_pix_if.sv
interface hsv_pix_if;
  import hsv_pkg::*;

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [PCT_W-1:0] saturation;
  logic [PCT_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// File: src/hsv_rgb_if.sv
interface hsv_rgb_if;
  import hsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            range_error;

  modport source (output valid, output red, output green, output blue,
                  output range_error, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input range_error, output ready);
endinterface

// File: src/hsv_norm.sv
module hsv_norm #(
  parameter int unsigned FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  hsv_pix_if.sink               pix_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output logic [FRAC_BITS:0]    sf_o,
  output logic [FRAC_BITS:0]    vf_o,
  output logic [hsv_pkg::K_W-1:0] k_o,
  output hsv_pkg::hsv_ctrl_t    ctrl_o
);
  import hsv_pkg::*;

  localparam int unsigned FW    = FRAC_BITS + 1;
  localparam int unsigned TAB_W = FRAC_BITS - PCT_SHIFT;
  localparam int unsigned PW    = PCT_W + PCT_RECIP_W;

  localparam logic [HUE_W-1:0] BASE1 = HUE_W'(SECTOR_SPAN);
  localparam logic [HUE_W-1:0] BASE2 = HUE_W'(2 * SECTOR_SPAN);
  localparam logic [HUE_W-1:0] BASE3 = HUE_W'(3 * SECTOR_SPAN);
  localparam logic [HUE_W-1:0] BASE4 = HUE_W'(4 * SECTOR_SPAN);
  localparam logic [HUE_W-1:0] BASE5 = HUE_W'(5 * SECTOR_SPAN);

  typedef logic [TAB_W-1:0] frac_tab_t [PCT_TAB_N];

  // Fraction of a residue modulo 25, built at elaboration.
  function automatic frac_tab_t build_tab();
    frac_tab_t t;
    for (int i = 0; i < PCT_TAB_N; i++) begin
      if (i < PCT_RESID_DIV) begin
        t[i] = TAB_W'((64'(i) << TAB_W) / PCT_RESID_DIV);
      end else begin
        t[i] = '0;
      end
    end
    return t;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_tab();

  // Percent times 16 to a fraction with FRAC_BITS fraction bits.
  function automatic logic [FW-1:0] pct_to_fix(logic [PCT_W-1:0] p);
    logic [PW-1:0]      prod;
    logic [PCT_Q_W-1:0] q;
    logic [PCT_W-1:0]   base;
    logic [RES_W-1:0]   r;
    prod = {{PCT_RECIP_W{1'b0}}, p} * {{PCT_W{1'b0}}, PCT_RECIP};
    q    = prod[PCT_RECIP_SHIFT +: PCT_Q_W];
    base = PCT_W'(q) * PCT_W'(PCT_RESID_DIV);
    r    = RES_W'(p - base);
    return FW'({q, FRAC_TAB[r]});
  endfunction

  logic [FW-1:0]    sf_d, vf_d;
  logic [K_W-1:0]   k_d;
  hsv_ctrl_t        ctrl_d;
  logic [HUE_W-1:0] base, rem;
  logic             odd;
  logic             vld_q;
  logic             load;
  logic [FW-1:0]    sf_q, vf_q;
  logic [K_W-1:0]   k_q;
  hsv_ctrl_t        ctrl_q;

  // Conversion of the two percentages.
  always_comb begin
    sf_d = pct_to_fix(pix_i.saturation);
    vf_d = pct_to_fix(pix_i.brightness);
  end

  // Range check, sector of the hue and its position inside the sector. A
  // full turn lands at the far end of the last sector.
  always_comb begin
    ctrl_d.err = (pix_i.hue > HUE_FULL) || (pix_i.saturation > PCT_FULL) ||
                 (pix_i.brightness > PCT_FULL);
    priority if (pix_i.hue >= BASE5) begin
      ctrl_d.sector = SECTOR_MAGENTA_RED;
      base          = BASE5;
    end else if (pix_i.hue >= BASE4) begin
      ctrl_d.sector = SECTOR_BLUE_MAGENTA;
      base          = BASE4;
    end else if (pix_i.hue >= BASE3) begin
      ctrl_d.sector = SECTOR_CYAN_BLUE;
      base          = BASE3;
    end else if (pix_i.hue >= BASE2) begin
      ctrl_d.sector = SECTOR_GREEN_CYAN;
      base          = BASE2;
    end else if (pix_i.hue >= BASE1) begin
      ctrl_d.sector = SECTOR_YELLOW_GREEN;
      base          = BASE1;
    end else begin
      ctrl_d.sector = SECTOR_RED_YELLOW;
      base          = '0;
    end
    rem = pix_i.hue - base;
    odd = (ctrl_d.sector == SECTOR_YELLOW_GREEN) || (ctrl_d.sector == SECTOR_CYAN_BLUE) ||
          (ctrl_d.sector == SECTOR_MAGENTA_RED);
    k_d = odd ? (K_W'(SECTOR_SPAN) - rem[K_W-1:0]) : rem[K_W-1:0];
  end

  // Stage register; it takes a new pixel whenever it is empty or drains.
  assign pix_i.ready = !vld_q || rdy_i;
  assign load        = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pix_i.ready) begin
      vld_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sf_q   <= sf_d;
      vf_q   <= vf_d;
      k_q    <= k_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign vld_o  = vld_q;
  assign sf_o   = sf_q;
  assign vf_o   = vf_q;
  assign k_o    = k_q;
  assign ctrl_o = ctrl_q;

  // The position inside a sector never passes the sector span.
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && !ctrl_q.err |-> k_q <= K_W'(SECTOR_SPAN))
    else $error("sector position beyond span");

endmodule

// File: src/hsv_chroma.sv
module hsv_chroma #(
  parameter int unsigned FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  output logic                    rdy_o,
  input  logic [FRAC_BITS:0]      sf_i,
  input  logic [FRAC_BITS:0]      vf_i,
  input  logic [hsv_pkg::K_W-1:0] k_i,
  input  hsv_pkg::hsv_ctrl_t      ctrl_i,
  output logic                    vld_o,
  input  logic                    rdy_i,
  output logic [FRAC_BITS:0]      red_o,
  output logic [FRAC_BITS:0]      green_o,
  output logic [FRAC_BITS:0]      blue_o,
  output logic                    err_o
);
  import hsv_pkg::*;

  localparam int unsigned FW = FRAC_BITS + 1;
  localparam int unsigned XW = FW + K_W;
  localparam int unsigned YW = XW - SPAN_SHIFT;
  localparam int unsigned QW = YW + SPAN_RECIP_W;

  // Valid bit and ready of each of the four stages.
  logic [3:0] v_q;
  logic [3:0] rdy;

  // Stage two: chroma.
  logic [2*FW-1:0] cprod;
  logic [FW-1:0]   cf2_q, vf2_q;
  logic [K_W-1:0]  k2_q;
  hsv_ctrl_t       ctrl2_q;
  // Stage three: chroma times sector position, offset.
  logic [XW-1:0]   xprod;
  logic [FW-1:0]   cf3_q, mf3_q;
  logic [YW-1:0]   y3_q;
  hsv_ctrl_t       ctrl3_q;
  // Stage four: estimated quotient by fifteen.
  logic [QW-1:0]   qprod;
  logic [FW-1:0]   cf4_q, mf4_q, qp4_q;
  logic [YW-1:0]   y4_q;
  hsv_ctrl_t       ctrl4_q;
  // Stage five: channel sums.
  logic [YW-1:0]   resid;
  logic [FW-1:0]   xf;
  logic [FW-1:0]   rc, gc, bc;
  logic [FW-1:0]   red_q, grn_q, blu_q;
  logic            err5_q;

  // A stage moves on when it is empty or the next one takes its pixel.
  assign rdy[3] = !v_q[3] || rdy_i;
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];
  assign rdy[0] = !v_q[0] || rdy[1];
  assign rdy_o  = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= vld_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
    end
  end

  assign cprod = {{FW{1'b0}}, sf_i} * {{FW{1'b0}}, vf_i};
  assign xprod = {{K_W{1'b0}}, cf2_q} * {{FW{1'b0}}, k2_q};
  assign qprod = {{SPAN_RECIP_W{1'b0}}, y3_q} * {{YW{1'b0}}, SPAN_RECIP};

  // The reciprocal estimate is at most one short; one compare fixes it.
  always_comb begin
    resid = y4_q - (YW'(qp4_q) * YW'(SPAN_ODD));
    xf    = qp4_q + FW'(resid >= YW'(SPAN_ODD));
  end

  // Order chroma, intermediate and zero by sector.
  always_comb begin
    unique case (ctrl4_q.sector)
      SECTOR_RED_YELLOW: begin
        rc = cf4_q; gc = xf;    bc = '0;
      end
      SECTOR_YELLOW_GREEN: begin
        rc = xf;    gc = cf4_q; bc = '0;
      end
      SECTOR_GREEN_CYAN: begin
        rc = '0;    gc = cf4_q; bc = xf;
      end
      SECTOR_CYAN_BLUE: begin
        rc = '0;    gc = xf;    bc = cf4_q;
      end
      SECTOR_BLUE_MAGENTA: begin
        rc = xf;    gc = '0;    bc = cf4_q;
      end
      default: begin
        rc = cf4_q; gc = '0;    bc = xf;
      end
    endcase
  end

  // Pipeline data registers.
  always_ff @(posedge clk_i) begin
    if (rdy[0] && vld_i) begin
      cf2_q   <= cprod[FRAC_BITS +: FW];
      vf2_q   <= vf_i;
      k2_q    <= k_i;
      ctrl2_q <= ctrl_i;
    end
    if (rdy[1] && v_q[0]) begin
      cf3_q   <= cf2_q;
      mf3_q   <= vf2_q - cf2_q;
      y3_q    <= xprod[SPAN_SHIFT +: YW];
      ctrl3_q <= ctrl2_q;
    end
    if (rdy[2] && v_q[1]) begin
      cf4_q   <= cf3_q;
      mf4_q   <= mf3_q;
      y4_q    <= y3_q;
      qp4_q   <= qprod[SPAN_RECIP_W +: FW];
      ctrl4_q <= ctrl3_q;
    end
    if (rdy[3] && v_q[2]) begin
      red_q  <= rc + mf4_q;
      grn_q  <= gc + mf4_q;
      blu_q  <= bc + mf4_q;
      err5_q <= ctrl4_q.err;
    end
  end

  assign vld_o   = v_q[3];
  assign red_o   = red_q;
  assign green_o = grn_q;
  assign blue_o  = blu_q;
  assign err_o   = err5_q;

  // The intermediate component never exceeds chroma.
  a_x_le_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] && !ctrl4_q.err |-> xf <= cf4_q)
    else $error("intermediate component above chroma");

  // A stalled last stage keeps its pixel.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] && !rdy_i |=> v_q[3] && $stable(red_q) && $stable(grn_q) && $stable(blu_q))
    else $error("stalled pixel lost");

endmodule

// File: src/hsv_scale.sv
module hsv_scale #(
  parameter int unsigned FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  output logic               rdy_o,
  input  logic [FRAC_BITS:0] red_i,
  input  logic [FRAC_BITS:0] green_i,
  input  logic [FRAC_BITS:0] blue_i,
  input  logic               err_i,
  hsv_rgb_if.source          rgb_o
);
  import hsv_pkg::*;

  localparam int unsigned FW = FRAC_BITS + 1;
  localparam int unsigned SW = FW + CH_W;

  // Scale a fraction by 255 and keep the integer part.
  function automatic logic [CH_W-1:0] to_channel(logic [FW-1:0] f);
    logic [SW-1:0] s;
    s = {f, {CH_W{1'b0}}} - {{CH_W{1'b0}}, f};
    return s[FRAC_BITS +: CH_W];
  endfunction

  logic            vld_q;
  logic [CH_W-1:0] red_q, grn_q, blu_q;
  logic            err_q;

  assign rdy_o = !vld_q || rgb_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  // Output register; an out-of-range pixel gives black.
  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      red_q <= err_i ? '0 : to_channel(red_i);
      grn_q <= err_i ? '0 : to_channel(green_i);
      blu_q <= err_i ? '0 : to_channel(blue_i);
      err_q <= err_i;
    end
  end

  assign rgb_o.valid       = vld_q;
  assign rgb_o.red         = red_q;
  assign rgb_o.green       = grn_q;
  assign rgb_o.blue        = blu_q;
  assign rgb_o.range_error = err_q;

  // A flagged pixel carries no colour.
  a_err_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && err_q |-> red_q == '0 && grn_q == '0 && blu_q == '0)
    else $error("range error with non-zero channels");

endmodule

// File: src/hsv_to_rgb_converter.sv
// HSV to RGB pixel converter. Each transfer on pix_i carries one pixel with
// hue in degrees and saturation and value in percent, all with four fraction
// bits; each transfer on rgb_o returns one 8-bit RGB pixel, truncated toward
// zero, in the same order. A pixel with any field above its range (hue over
// 360 degrees, saturation or value over 100 percent) comes out black with
// range_error set. The datapath is a six-stage pipeline (range check and
// normalisation, chroma multiply, sector multiply, reciprocal multiply for
// the division by fifteen, channel sums, scaling by 255 in the output
// register), so a new pixel is taken on every clock while rgb_o is not
// stalled, and its result is offered on rgb_o from the output register.
// Each stage holds its pixel while the next is full, and empty stages keep
// filling during a stall. Internal fractions carry FRAC_BITS fraction bits.
// There is no state between pixels and no start-up pass after reset.
module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsv_pix_if.sink   pix_i,
  hsv_rgb_if.source rgb_o
);
  import hsv_pkg::*;

  logic               n_vld, n_rdy;
  logic [FRAC_BITS:0] n_sf, n_vf;
  logic [K_W-1:0]     n_k;
  hsv_ctrl_t          n_ctrl;

  logic               c_vld, c_rdy;
  logic [FRAC_BITS:0] c_red, c_green, c_blue;
  logic               c_err;

  hsv_norm #(
    .FRAC_BITS (FRAC_BITS)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .vld_o  (n_vld),
    .rdy_i  (n_rdy),
    .sf_o   (n_sf),
    .vf_o   (n_vf),
    .k_o    (n_k),
    .ctrl_o (n_ctrl)
  );

  hsv_chroma #(
    .FRAC_BITS (FRAC_BITS)
  ) u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (n_vld),
    .rdy_o   (n_rdy),
    .sf_i    (n_sf),
    .vf_i    (n_vf),
    .k_i     (n_k),
    .ctrl_i  (n_ctrl),
    .vld_o   (c_vld),
    .rdy_i   (c_rdy),
    .red_o   (c_red),
    .green_o (c_green),
    .blue_o  (c_blue),
    .err_o   (c_err)
  );

  hsv_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (c_vld),
    .rdy_o   (c_rdy),
    .red_i   (c_red),
    .green_i (c_green),
    .blue_i  (c_blue),
    .err_i   (c_err),
    .rgb_o   (rgb_o)
  );

endmodule

// File: sim/hsv_to_rgb_checker.sv
`timescale 1ns / 100ps

module hsv_to_rgb_checker #(
  parameter int unsigned FRAC_BITS = hsv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsv_pix_if          pix_i,
  hsv_rgb_if          rgb_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned range_errors_o
);
  import hsv_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            range_error;
  } rgb_pixel_t;

  // Pixels still owed by the block, oldest first.
  rgb_pixel_t  expected_rgb_q[$];
  rgb_pixel_t  want_px;
  rgb_pixel_t  got_px;
  int unsigned pixels_in;
  int unsigned pixels_out;
  int unsigned fails;
  int unsigned range_errs;

  // A fraction with FRAC_BITS fraction bits scaled to 0..255, truncated.
  function automatic logic [CH_W-1:0] scale_channel(longint unsigned frac);
    return CH_W'((frac * 255) >> FRAC_BITS);
  endfunction

  // Expected RGB pixel for one HSV pixel.
  function automatic rgb_pixel_t hsv_to_rgb_expected(logic [HUE_W-1:0] hue,
                                                     logic [PCT_W-1:0] sat,
                                                     logic [PCT_W-1:0] val);
    rgb_pixel_t      px;
    sector_e         sector;
    longint unsigned sat_f, val_f, chroma, offset, inter, span_pos, weight;
    longint unsigned comp_r, comp_g, comp_b;
    px = '0;
    // Anything out of range comes back black with the error flag.
    if (hue > HUE_FULL || sat > PCT_FULL || val > PCT_FULL) begin
      px.range_error = 1'b1;
      return px;
    end
    sat_f  = (longint'(sat) << FRAC_BITS) / longint'(PCT_FULL);
    val_f  = (longint'(val) << FRAC_BITS) / longint'(PCT_FULL);
    chroma = (sat_f * val_f) >> FRAC_BITS;
    offset = val_f - chroma;
    // A hue of a full turn stays in the last sector at its far end.
    if (hue == HUE_FULL) begin
      sector = SECTOR_MAGENTA_RED;
    end else begin
      sector = sector_e'(hue / SECTOR_SPAN);
    end
    span_pos = longint'(hue) - longint'(sector) * SECTOR_SPAN;
    weight   = sector[0] ? SECTOR_SPAN - span_pos : span_pos;
    inter    = (chroma * weight) / SECTOR_SPAN;
    comp_r = 0;
    comp_g = 0;
    comp_b = 0;
    case (sector)
      SECTOR_RED_YELLOW: begin
        comp_r = chroma;
        comp_g = inter;
      end
      SECTOR_YELLOW_GREEN: begin
        comp_r = inter;
        comp_g = chroma;
      end
      SECTOR_GREEN_CYAN: begin
        comp_g = chroma;
        comp_b = inter;
      end
      SECTOR_CYAN_BLUE: begin
        comp_g = inter;
        comp_b = chroma;
      end
      SECTOR_BLUE_MAGENTA: begin
        comp_r = inter;
        comp_b = chroma;
      end
      default: begin
        comp_r = chroma;
        comp_b = inter;
      end
    endcase
    px.red   = scale_channel(comp_r + offset);
    px.green = scale_channel(comp_g + offset);
    px.blue  = scale_channel(comp_b + offset);
    return px;
  endfunction

  function automatic int unsigned field_mismatch(string name, int unsigned want,
                                                 int unsigned got);
    if (want == got) begin
      return 0;
    end
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  // Outputs are compared before the input transfer of the same edge is
  // queued, so a result can never match a pixel taken at that very edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rgb_q.delete();
      pixels_in      = 0;
      pixels_out     = 0;
      fails          = 0;
      range_errs     = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      checked_o      <= 0;
      range_errors_o <= 0;
    end else begin
      if (rgb_i.valid && rgb_i.ready) begin
        got_px = {rgb_i.red, rgb_i.green, rgb_i.blue, rgb_i.range_error};
        if (expected_rgb_q.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d err=%0b",
                   $time, got_px.red, got_px.green, got_px.blue, got_px.range_error);
          fails++;
        end else begin
          want_px = expected_rgb_q.pop_front();
          pixels_out++;
          if (want_px.range_error) begin
            range_errs++;
          end
          fails += field_mismatch("red", 32'(want_px.red), 32'(got_px.red))
                 + field_mismatch("green", 32'(want_px.green), 32'(got_px.green))
                 + field_mismatch("blue", 32'(want_px.blue), 32'(got_px.blue))
                 + field_mismatch("range_error", 32'(want_px.range_error),
                                  32'(got_px.range_error));
        end
      end
      if (pix_i.valid && pix_i.ready) begin
        expected_rgb_q.push_back(hsv_to_rgb_expected(pix_i.hue, pix_i.saturation,
                                                     pix_i.brightness));
        pixels_in++;
      end
      fail_count_o   <= fails;
      pending_o      <= pixels_in - pixels_out;
      checked_o      <= pixels_out;
      range_errors_o <= range_errs;
    end
  end

endmodule

// File: sim/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  localparam int unsigned FRAC         = FRAC_BITS_DEFAULT;
  localparam int unsigned RANDOM_PER   = 560;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned STUCK_LIMIT  = 5000;

  logic        clk;
  logic        rst_n;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_req;
  int unsigned pixels_sent;
  int unsigned directed_sent;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned range_errors;

  hsv_pix_if pix ();
  hsv_rgb_if rgb ();

  hsv_to_rgb_converter #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .pix_i (pix),
    .rgb_o (rgb)
  );

  hsv_to_rgb_checker #(
    .FRAC_BITS(FRAC)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .pix_i         (pix),
    .rgb_i         (rgb),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .range_errors_o(range_errors)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: random back-pressure, or one long hold when asked for.
  initial begin : sink_side
    bit held;
    held      = 1'b0;
    rgb.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        rgb.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        rgb.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((pix.valid && pix.ready) || (rgb.valid && rgb.ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
    $display("** hsv_to_rgb_converter: FAILED **");
    $finish;
  end

  // Offers one pixel after a random gap and waits for its transfer.
  task automatic send_pixel(input logic [HUE_W-1:0] h, input logic [PCT_W-1:0] s,
                            input logic [PCT_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.hue        <= h;
    pix.saturation <= s;
    pix.brightness <= v;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // Mostly in-range pixels, with sector edges and out-of-range fields mixed in.
  task automatic send_random_pixel();
    int unsigned      pick;
    logic [HUE_W-1:0] h;
    logic [PCT_W-1:0] s;
    logic [PCT_W-1:0] v;
    pick = $urandom_range(99);
    h = HUE_W'($urandom_range(int'(HUE_FULL)));
    s = PCT_W'($urandom_range(int'(PCT_FULL)));
    v = PCT_W'($urandom_range(int'(PCT_FULL)));
    if (pick < 6) begin
      h = HUE_W'($urandom_range((1 << HUE_W) - 1, int'(HUE_FULL) + 1));
    end else if (pick < 10) begin
      s = PCT_W'($urandom_range((1 << PCT_W) - 1, int'(PCT_FULL) + 1));
    end else if (pick < 14) begin
      v = PCT_W'($urandom_range((1 << PCT_W) - 1, int'(PCT_FULL) + 1));
    end else if (pick < 24) begin
      // Around a sector boundary with saturation or value at an end.
      h = HUE_W'(SECTOR_SPAN * $urandom_range(6) + $urandom_range(2));
      if ($urandom_range(1)) begin
        s = $urandom_range(1) ? PCT_FULL : '0;
      end else begin
        v = $urandom_range(1) ? PCT_FULL : '0;
      end
    end
    send_pixel(h, s, v);
  endtask

  // Stimulus and verdict.
  initial begin
    pix.valid      = 1'b0;
    pix.hue        = '0;
    pix.saturation = '0;
    pix.brightness = '0;
    hold_req       = 1'b0;
    pixels_sent    = 0;
    src_idle_pct   = 23;
    sink_idle_pct  = 77;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pixels: range ends, each sector start, full turn, errors.
    send_pixel('0, '0, '0);
    send_pixel('0, PCT_FULL, PCT_FULL);
    send_pixel(13'd960, PCT_FULL, PCT_FULL);
    send_pixel(13'd1920, PCT_FULL, PCT_FULL);
    send_pixel(13'd2880, PCT_FULL, PCT_FULL);
    send_pixel(13'd3840, PCT_FULL, PCT_FULL);
    send_pixel(13'd4800, PCT_FULL, PCT_FULL);
    send_pixel(HUE_FULL, PCT_FULL, PCT_FULL);
    send_pixel(HUE_FULL, 11'd800, 11'd1200);
    send_pixel('0, 11'd800, 11'd1200);
    send_pixel(13'd480, 11'd800, 11'd1200);
    send_pixel(13'd1440, 11'd1600, 11'd800);
    send_pixel(13'd2400, 11'd333, 11'd1599);
    send_pixel(13'd3360, 11'd1, 11'd1);
    send_pixel(13'd4320, 11'd1599, 11'd1600);
    send_pixel(13'd5759, PCT_FULL, PCT_FULL);
    send_pixel(13'd959, PCT_FULL, 11'd1000);
    send_pixel(13'd3000, '0, PCT_FULL);
    send_pixel(13'd5761, PCT_FULL, PCT_FULL);
    send_pixel(13'd8191, 11'd2047, 11'd2047);
    send_pixel(13'd100, 11'd1601, 11'd800);
    send_pixel(13'd100, 11'd800, 11'd1601);
    send_pixel(13'd100, 11'd2047, '0);
    send_pixel(13'd4096, 11'd1024, 11'd1024);
    directed_sent = pixels_sent;

    // Three random phases with different idling on each side.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 23;
          sink_idle_pct = 77;
        end
        1: begin
          src_idle_pct  = 77;
          sink_idle_pct = 23;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < RANDOM_PER; i++) begin
        // Stall the output long enough for the pipeline to back up.
        if (phase == 2 && i == 150) begin
          hold_req = 1'b1;
        end
        send_random_pixel();
      end
    end
    pix.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixels (%0d directed), %0d results compared, %0d out of range,",
             pixels_sent, directed_sent, checked, range_errors);
    $display("under three idling mixes and one %0d-cycle output hold.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("** hsv_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
src/hsv_pkg.sv
src/hsv_pix_if.sv
src/hsv_rgb_if.sv
src/hsv_norm.sv
src/hsv_chroma.sv
src/hsv_scale.sv
src/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_checker.sv
sim/hsv_to_rgb_converter_tb.sv
